[rtl/tfb_pkg.sv]
// ----------------------------------------------------------------------------
// tfb_pkg: shared types, constants and the CRC function of the telemetry frame builder
// Holds the record type, the frame byte positions and the CRC-8/Maxim update.
// ----------------------------------------------------------------------------
package tfb_pkg;

  // Depth of the record queue between the front and the back.
  localparam int QUEUE_DEPTH_DEF = 2;

  // Frame layout.
  localparam int FRAME_LEN = 13;
  localparam int IDX_W     = $clog2(FRAME_LEN);

  localparam logic [7:0] HEAD_BYTE     = 8'h53;
  localparam logic [7:0] TAIL_BYTE     = 8'h45;
  localparam logic [7:0] CRC_POLY_REFL = 8'h8C;

  // Byte positions within one frame.
  localparam logic [IDX_W-1:0] IDX_HEAD      = IDX_W'(0);
  localparam logic [IDX_W-1:0] IDX_FOUND     = IDX_W'(1);
  localparam logic [IDX_W-1:0] IDX_FIRE      = IDX_W'(2);
  localparam logic [IDX_W-1:0] IDX_YAW_SIGN  = IDX_W'(3);
  localparam logic [IDX_W-1:0] IDX_YAW_LO    = IDX_W'(4);
  localparam logic [IDX_W-1:0] IDX_YAW_HI    = IDX_W'(5);
  localparam logic [IDX_W-1:0] IDX_PITCH_SGN = IDX_W'(6);
  localparam logic [IDX_W-1:0] IDX_PITCH_LO  = IDX_W'(7);
  localparam logic [IDX_W-1:0] IDX_PITCH_HI  = IDX_W'(8);
  localparam logic [IDX_W-1:0] IDX_DEPTH_LO  = IDX_W'(9);
  localparam logic [IDX_W-1:0] IDX_DEPTH_HI  = IDX_W'(10);
  localparam logic [IDX_W-1:0] IDX_CRC       = IDX_W'(11);
  localparam logic [IDX_W-1:0] IDX_TAIL      = IDX_W'(12);

  // One aiming record as it travels from the front to the back.
  typedef struct packed {
    logic [7:0]         target_found;
    logic [7:0]         fire_command;
    logic [7:0]         yaw_sign;
    logic signed [15:0] yaw_value;
    logic [7:0]         pitch_sign;
    logic signed [15:0] pitch_value;
    logic signed [15:0] depth_value;
  } record_t;

  // One byte of CRC-8/Maxim, shift-right form, eight bit steps.
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int b = 0; b < 8; b++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY_REFL;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

[rtl/tfb_front.sv]
// ----------------------------------------------------------------------------
// tfb_front: input side of the telemetry frame builder
// Accepts aiming records and holds them in a short queue for the back.
// ----------------------------------------------------------------------------
module tfb_front import tfb_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  output logic    full,
  input  record_t push_rec,
  output logic    rec_valid,
  output record_t rec,
  input  logic    rec_take
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  record_t          mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push;
  logic             do_pop;

  assign full      = (count_r == CNT_FULL);
  assign rec_valid = (count_r != '0);
  assign rec       = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = rec_take && rec_valid;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Record storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_rec;
    end
  end

  // The fill count never passes the queue depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_FULL) else $error("record queue overfilled");

  // A push into a non-full queue with no pop raises the count by one.
  a_push_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("push not counted");

  // A pop with no push lowers the count by one.
  a_pop_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (do_pop && !do_push) |=> (count_r == $past(count_r) - CNT_W'(1)))
    else $error("pop not counted");

endmodule

[rtl/tfb_back.sv]
// ----------------------------------------------------------------------------
// tfb_back: output side of the telemetry frame builder
// Serializes one record into the 13-byte frame, running the CRC as it goes.
// ----------------------------------------------------------------------------
module tfb_back import tfb_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       rec_valid,
  input  record_t    rec,
  output logic       rec_take,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] frame_byte,
  output logic       frame_last
);

  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [7:0]       crc_r, crc_nxt;
  logic             ovalid_r, ovalid_nxt;
  logic [7:0]       obyte_r;
  logic             olast_r;
  logic [7:0]       cur_byte;
  logic             advance;

  // A new word may be produced when the output register is free or being drained.
  assign advance  = rec_valid && (!ovalid_r || pop);
  assign rec_take = advance && (idx_r == IDX_TAIL);

  assign empty      = !ovalid_r;
  assign frame_byte = obyte_r;
  assign frame_last = olast_r;

  // Byte selector for the current frame position.
  always_comb begin
    unique case (idx_r)
      IDX_HEAD:      cur_byte = HEAD_BYTE;
      IDX_FOUND:     cur_byte = rec.target_found;
      IDX_FIRE:      cur_byte = rec.fire_command;
      IDX_YAW_SIGN:  cur_byte = rec.yaw_sign;
      IDX_YAW_LO:    cur_byte = rec.yaw_value[7:0];
      IDX_YAW_HI:    cur_byte = rec.yaw_value[15:8];
      IDX_PITCH_SGN: cur_byte = rec.pitch_sign;
      IDX_PITCH_LO:  cur_byte = rec.pitch_value[7:0];
      IDX_PITCH_HI:  cur_byte = rec.pitch_value[15:8];
      IDX_DEPTH_LO:  cur_byte = rec.depth_value[7:0];
      IDX_DEPTH_HI:  cur_byte = rec.depth_value[15:8];
      IDX_CRC:       cur_byte = crc_r;
      IDX_TAIL:      cur_byte = TAIL_BYTE;
      default:       cur_byte = TAIL_BYTE;
    endcase
  end

  // Position counter, running CRC and output register valid.
  always_comb begin
    idx_nxt    = idx_r;
    crc_nxt    = crc_r;
    ovalid_nxt = ovalid_r;
    if (advance) begin
      ovalid_nxt = 1'b1;
      idx_nxt    = (idx_r == IDX_TAIL) ? IDX_HEAD : idx_r + IDX_W'(1);
      if (idx_r == IDX_HEAD) begin
        crc_nxt = crc8_step(8'h00, cur_byte);
      end else if (idx_r <= IDX_DEPTH_HI) begin
        crc_nxt = crc8_step(crc_r, cur_byte);
      end
    end else if (pop) begin
      ovalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r    <= IDX_HEAD;
      ovalid_r <= 1'b0;
    end else begin
      idx_r    <= idx_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    crc_r <= crc_nxt;
    if (advance) begin
      obyte_r <= cur_byte;
      olast_r <= (idx_r == IDX_TAIL);
    end
  end

  // The last word of a frame is always the tail byte.
  a_last_is_tail: assert property (@(posedge clk) disable iff (!rst_n)
    (ovalid_r && olast_r) |-> (obyte_r == TAIL_BYTE)) else $error("bad frame tail");

  // The position counter stays inside the frame.
  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= IDX_TAIL) else $error("frame position out of range");

  // Emitting the tail returns the counter to the head of the next frame.
  a_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    rec_take |=> (idx_r == IDX_HEAD && ovalid_r && olast_r))
    else $error("frame did not wrap");

endmodule

[rtl/telemetry_frame_builder_crc8_top.sv]
// ----------------------------------------------------------------------------
// telemetry_frame_builder_crc8_top: aiming record to CRC-8 framed byte stream
// Top level joining the record queue and the frame serializer.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive the record fields and raise in_push; a word is taken
//   at a clock edge where in_push is high and in_full is low. The front holds
//   up to QUEUE_DEPTH records, so pushes are taken while a frame is sent.
//   Result channel: while out_empty is low, out_frame_byte holds the oldest
//   frame byte; out_frame_last marks the trailing 0x45. Raise out_pop to take
//   a word.
//   Each record yields 13 words: 0x53, found, fire, yaw sign, yaw lo/hi,
//   pitch sign, pitch lo/hi, depth lo/hi, CRC-8/Maxim over the first 11
//   bytes, 0x45.
//   A pushed record is first written into the queue; its first byte then goes
//   into the output register. The single output register of the serializer
//   sends one byte per cycle while out_pop is high and a record is queued.
//   Reset (rst_n low, synchronous) empties the queue and the output register.
//   When the receiver stalls, the current byte holds and the queue fills,
//   after which in_full rises.
// ----------------------------------------------------------------------------
module telemetry_frame_builder_crc8_top import tfb_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [7:0]  in_target_found,
  input  logic [7:0]  in_fire_command,
  input  logic [7:0]  in_yaw_sign,
  input  logic signed [15:0] in_yaw_value,
  input  logic [7:0]  in_pitch_sign,
  input  logic signed [15:0] in_pitch_value,
  input  logic signed [15:0] in_depth_value,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [7:0]  out_frame_byte,
  output logic        out_frame_last
);

  record_t push_rec;
  record_t rec;
  logic    rec_valid;
  logic    rec_take;

  // Pack the input word into a record.
  always_comb begin
    push_rec.target_found = in_target_found;
    push_rec.fire_command = in_fire_command;
    push_rec.yaw_sign     = in_yaw_sign;
    push_rec.yaw_value    = in_yaw_value;
    push_rec.pitch_sign   = in_pitch_sign;
    push_rec.pitch_value  = in_pitch_value;
    push_rec.depth_value  = in_depth_value;
  end

  tfb_front #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_push),
    .full      (in_full),
    .push_rec  (push_rec),
    .rec_valid (rec_valid),
    .rec       (rec),
    .rec_take  (rec_take)
  );

  tfb_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .rec_valid  (rec_valid),
    .rec        (rec),
    .rec_take   (rec_take),
    .empty      (out_empty),
    .pop        (out_pop),
    .frame_byte (out_frame_byte),
    .frame_last (out_frame_last)
  );

endmodule
